>>> sv/tkds_pkg.sv
// Shared types, constants and key selection for the top-k descending key sorter.
`default_nettype none

package tkds_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int TOP_COUNT   = 10;

    localparam int ADDR_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W   = 32;
    localparam int CENTS_W = 31;
    localparam int RANK_W  = 7;
    localparam int RECNO_W = 11;

    localparam logic [1:0] KEY_INCOME  = 2'd0;
    localparam logic [1:0] KEY_EXPENSE = 2'd1;
    localparam logic [1:0] KEY_BALANCE = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CENTS_W-1:0] income_cents;
        logic [CENTS_W-1:0] expense_cents;
        logic               last_record;
    } rec_t;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic [RECNO_W-1:0]        record_number;
        logic signed [KEY_W-1:0]   key_value;
        logic                      dropped_records;
        logic                      last_result;
    } res_t;

    // one entry offered to the compare unit, and the running winner
    typedef struct packed {
        logic                    valid;
        logic [ADDR_W-1:0]       idx;
        logic signed [KEY_W-1:0] key;
    } cand_t;

    function automatic logic signed [KEY_W-1:0] pick_key(
        input logic [1:0]         sel,
        input logic [CENTS_W-1:0] inc,
        input logic [CENTS_W-1:0] exp
    );
        logic signed [KEY_W-1:0] a;
        logic signed [KEY_W-1:0] b;
        logic signed [KEY_W-1:0] k;
        a = $signed({1'b0, inc});
        b = $signed({1'b0, exp});
        case (sel)
            KEY_INCOME:  k = a;
            KEY_EXPENSE: k = b;
            KEY_BALANCE: k = a - b;
            default:     k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> sv/top_k_descending_key_sorter_core.sv
// Top level: record loading, selection sequencer and result register.
//
// Records are taken one per cycle while loading; each record's key is formed from
// sort_key at the time of its transfer and written to a 64-entry key memory. The
// record flagged last closes the set and the block stops taking records. It then
// picks the ranked entries one at a time: for each rank a single compare unit walks
// every stored key through the memory's read port, skipping entries already ranked,
// and min(N, 10) ranks are emitted for a set of N stored records before records are
// taken again. Equal keys come out in arrival order. Records beyond 64 are dropped
// and flagged on every result of that set. A result waits in an output register
// while stalled.
`default_nettype none

module top_k_descending_key_sorter_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rec_valid,
    output logic                rec_stall,
    input  wire tkds_pkg::rec_t rec,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tkds_pkg::res_t      res,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_data
);
    import tkds_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]          sort_key_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [RANK_W-1:0]   emit_reg, emit_next;
    logic                drop_reg, drop_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [MAX_RECORDS-1:0] taken_reg, taken_next;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic rec_acc;
    logic full;
    logic close_set;
    logic scan_end;
    logic last_rank;
    logic emit_go;
    logic rd_en;
    logic best_clr;
    logic signed [KEY_W-1:0] rd_key;
    cand_t cand;
    cand_t best;
    logic [RANK_W-1:0] rank_inc;

    assign rec_acc   = rec_valid && !rec_stall;
    assign full      = (count_reg == CNT_W'(MAX_RECORDS));
    assign close_set = rec_acc && rec.last_record;
    assign scan_end  = (scan_reg == ADDR_W'(n_reg - CNT_W'(1)));
    assign rank_inc  = rank_reg + RANK_W'(1);
    assign last_rank = (rank_inc == emit_reg);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (close_set)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = last_rank ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        rec_stall = 1'b1;
        cfg_ready = 1'b0;
        rd_en     = 1'b0;
        best_clr  = 1'b0;
        emit_go   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                rec_stall = 1'b0;
                cfg_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en    = 1'b1;
                best_clr = (scan_reg == '0);
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_EMIT:
            begin
                emit_go = !res_valid_reg || !res_stall;
            end
            default:
            begin
                rec_stall = 1'b1;
            end
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        emit_next      = emit_reg;
        drop_next      = drop_reg;
        rank_next      = rank_reg;
        taken_next     = taken_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        scan_next      = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (rec_acc)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (rec.last_record)
            begin
                n_next     = full ? count_reg : count_reg + CNT_W'(1);
                emit_next  = (n_next < CNT_W'(TOP_COUNT)) ? RANK_W'(n_next)
                                                           : RANK_W'(TOP_COUNT);
                drop_next  = full || ovf_reg;
                rank_next  = '0;
                taken_next = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end

        if (state_reg == ST_SCAN && !scan_end)
        begin
            scan_next = scan_reg + ADDR_W'(1);
        end

        if (emit_go)
        begin
            res_next.rank            = rank_inc;
            res_next.record_number   = RECNO_W'(best.idx) + RECNO_W'(1);
            res_next.key_value       = best.key;
            res_next.dropped_records = drop_reg;
            res_next.last_result     = last_rank;
            res_valid_next           = 1'b1;
            taken_next[best.idx]     = 1'b1;
            rank_next                = rank_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            sort_key_reg  <= KEY_INCOME;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            emit_reg      <= '0;
            drop_reg      <= 1'b0;
            rank_reg      <= '0;
            scan_reg      <= '0;
            taken_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                sort_key_reg <= cfg_data;
            end
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            emit_reg      <= emit_next;
            drop_reg      <= drop_next;
            rank_reg      <= rank_next;
            scan_reg      <= scan_next;
            taken_reg     <= taken_next;
            rd_vld_reg    <= rd_en;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        res_reg    <= res_next;
    end

    tkds_key_mem u_key_mem (
        .clk     (clk),
        .wr_en   (rec_acc && !full),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (pick_key(sort_key_reg, rec.income_cents, rec.expense_cents)),
        .rd_en   (rd_en),
        .rd_addr (scan_reg),
        .rd_data (rd_key)
    );

    assign cand.valid = rd_vld_reg && !taken_reg[rd_idx_reg];
    assign cand.idx   = rd_idx_reg;
    assign cand.key   = rd_key;

    tkds_max_unit u_max_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (best_clr),
        .cand  (cand),
        .best  (best)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- assertions ----------------
    a_winner_present: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |-> best.valid)
        else $error("no winner when a rank is emitted");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (rank_reg < emit_reg))
        else $error("rank ran past the emit count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds capacity");

    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        close_set |=> rec_stall && (count_reg == '0) && !ovf_reg)
        else $error("set not closed after last record");

    a_taken_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> ($countones(taken_reg) == int'(rank_reg)))
        else $error("ranked entries do not match rank count");

endmodule

`default_nettype wire

>>> sv/tkds_key_mem.sv
// Key memory: one write port, one registered read port.
`default_nettype none

module tkds_key_mem (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [tkds_pkg::ADDR_W-1:0]    wr_addr,
    input  wire logic signed [tkds_pkg::KEY_W-1:0] wr_data,
    input  wire logic                           rd_en,
    input  wire logic [tkds_pkg::ADDR_W-1:0]    rd_addr,
    output logic signed [tkds_pkg::KEY_W-1:0]   rd_data
);
    import tkds_pkg::*;

    logic signed [KEY_W-1:0] mem [MAX_RECORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/tkds_max_unit.sv
// Shared compare unit: keeps the largest key seen in one pass, earliest on ties.
`default_nettype none

module tkds_max_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            clr,
    input  wire tkds_pkg::cand_t cand,
    output tkds_pkg::cand_t      best
);
    import tkds_pkg::*;

    cand_t best_reg;
    cand_t best_next;
    logic  take;

    // strict greater-than keeps the earlier entry on equal keys
    assign take = cand.valid && (!best_reg.valid || ($signed(cand.key) > $signed(best_reg.key)));

    always_comb
    begin
        best_next = best_reg;
        if (clr)
        begin
            best_next.valid = 1'b0;
        end
        else if (take)
        begin
            best_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire

>>> bench/top_k_descending_key_sorter_core_tb.sv
// Testbench for the top-k descending key sorter: directed table, random record sets, ranked-entry checks.
module top_k_descending_key_sorter_core_tb;

    import tkds_pkg::*;

    localparam int          RANDOM_RECORDS = 340;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          DRAIN_CYCLES   = 700;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int          PLAN_ROWS      = 21;

    localparam logic [1:0] KEY_UNUSED = 2'd3;

    // register write ahead of a table row: bit 2 set means leave the key as is
    localparam logic [2:0] NO_WRITE   = 3'b100;
    localparam logic [2:0] WR_INCOME  = {1'b0, KEY_INCOME};
    localparam logic [2:0] WR_EXPENSE = {1'b0, KEY_EXPENSE};
    localparam logic [2:0] WR_BALANCE = {1'b0, KEY_BALANCE};
    localparam logic [2:0] WR_UNUSED  = {1'b0, KEY_UNUSED};

    typedef struct packed {
        logic [2:0]              set_key;
        logic [CENTS_W-1:0]      income;
        logic [CENTS_W-1:0]      expense;
        logic                    last;
        logic                    typed;
        logic signed [KEY_W-1:0] top_key;
    } plan_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        rec_valid = 1'b0;
    logic        rec_stall;
    rec_t        rec       = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;

    // typed rows are single-record sets: rank 1, record 1, last entry, nothing dropped
    plan_row_t plan [PLAN_ROWS] = '{
        '{NO_WRITE,   31'h7FFFFFFF, 31'h00000000, 1'b1, 1'b1, 32'sh7FFFFFFF},
        '{NO_WRITE,   31'h00000000, 31'h7FFFFFFF, 1'b1, 1'b1, 32'sh00000000},
        '{WR_EXPENSE, 31'h00000005, 31'h7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
        '{NO_WRITE,   31'h7FFFFFFF, 31'h00000000, 1'b1, 1'b1, 32'sh00000000},
        '{WR_BALANCE, 31'h00000000, 31'h7FFFFFFF, 1'b1, 1'b1, 32'sh80000001},
        '{NO_WRITE,   31'h7FFFFFFF, 31'h00000000, 1'b1, 1'b1, 32'sh7FFFFFFF},
        '{NO_WRITE,   31'h2AAAAAAA, 31'h55555555, 1'b1, 1'b0, 32'sh0},
        '{NO_WRITE,   31'h55555555, 31'h2AAAAAAA, 1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b0, 32'sh0},
        '{WR_UNUSED,  31'd10,       31'd1,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd20,       31'd2,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd30,       31'd3,        1'b1, 1'b0, 32'sh0},
        '{WR_INCOME,  31'd7,        31'd0,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd9,        31'd0,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd7,        31'd0,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd9,        31'd0,        1'b1, 1'b0, 32'sh0},
        '{WR_BALANCE, 31'd100,      31'd200,      1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd300,      31'd100,      1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd0,        31'd0,        1'b0, 1'b0, 32'sh0},
        '{NO_WRITE,   31'd100,      31'd200,      1'b1, 1'b0, 32'sh0},
        '{WR_INCOME,  31'd0,        31'd0,        1'b1, 1'b1, 32'sh0}
    };

    // sorter image
    logic signed [KEY_W-1:0] held_key [MAX_RECORDS];
    logic [6:0]              held_count    = '0;
    logic                    held_overflow = 1'b0;
    logic [1:0]              key_sel       = KEY_INCOME;

    res_t        expected_ranks [$];
    res_t        oldest;
    logic        quiet         = 1'b0;
    int          errors        = 0;
    int          records_sent  = 0;
    int          sets_closed   = 0;
    int          overflow_sets = 0;
    int          ranks_checked = 0;
    int unsigned cycles        = 0;
    bit [3:0]    keys_used     = '0;

    top_k_descending_key_sorter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d ranked entries still outstanding", $time,
                     expected_ranks.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        res_stall <= !quiet && ($urandom_range(99) < 24);

    function automatic logic signed [KEY_W-1:0] key_of(input logic [1:0] sel,
                                                       input logic [CENTS_W-1:0] inc,
                                                       input logic [CENTS_W-1:0] spent);
        logic signed [KEY_W-1:0] k;
        case (sel)
            KEY_INCOME:  k = $signed({1'b0, inc});
            KEY_EXPENSE: k = $signed({1'b0, spent});
            KEY_BALANCE: k = $signed({1'b0, inc}) - $signed({1'b0, spent});
            default:     k = '0;
        endcase
        return k;
    endfunction

    // store the record's key; on the last record queue the top entries, stable descending
    task automatic rank_record(input rec_t r);
        bit   taken [MAX_RECORDS];
        int   best;
        int   emit;
        res_t e;
        if (held_count < MAX_RECORDS)
        begin
            held_key[held_count[5:0]] = key_of(key_sel, r.income_cents, r.expense_cents);
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (r.last_record)
        begin
            emit = (held_count < TOP_COUNT) ? held_count : TOP_COUNT;
            for (int rk = 0; rk < emit; rk++)
            begin
                best = -1;
                for (int i = 0; i < held_count; i++)
                    if (!taken[i] && (best < 0 || held_key[i] > held_key[best]))
                        best = i;
                taken[best]       = 1'b1;
                e.rank            = RANK_W'(rk + 1);
                e.record_number   = RECNO_W'(best + 1);
                e.key_value       = held_key[best];
                e.dropped_records = held_overflow;
                e.last_result     = (rk + 1 == emit);
                expected_ranks.push_back(e);
            end
            sets_closed++;
            if (held_overflow)
                overflow_sets++;
            held_count    = '0;
            held_overflow = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_ranks.size() == 0)
            begin
                $display("%0t: unexpected entry: expected none, actual rank %0d record %0d key %0d",
                         $time, res.rank, res.record_number, $signed(res.key_value));
                errors++;
            end
            else
            begin
                oldest = expected_ranks.pop_front();
                check_field("rank", oldest.rank, res.rank);
                check_field("record_number", oldest.record_number, res.record_number);
                check_field("key_value", $signed(oldest.key_value), $signed(res.key_value));
                check_field("dropped_records", oldest.dropped_records, res.dropped_records);
                check_field("last_result", oldest.last_result, res.last_result);
                ranks_checked++;
            end
        end
    end

    task automatic send_record(input rec_t r);
        while (!quiet && $urandom_range(99) < 24)
        begin
            rec_valid <= 1'b0;
            @(posedge clk);
        end
        rec_valid <= 1'b1;
        rec       <= r;
        do
            @(posedge clk);
        while (rec_stall);
        rank_record(r);
        records_sent++;
    endtask

    task automatic wait_for_results();
        rec_valid <= 1'b0;
        while (expected_ranks.size() != 0)
            @(posedge clk);
    endtask

    // key register changes only with the sorter idle
    task automatic write_sort_key(input logic [1:0] sel);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_sel         = sel;
        keys_used[sel]  = 1'b1;
    endtask

    function automatic logic [CENTS_W-1:0] random_cents();
        int mode;
        mode = $urandom_range(9);
        if (mode < 5)
            return CENTS_W'($urandom);
        else if (mode < 8)
            return CENTS_W'($urandom_range(15));
        else if (mode == 8)
            return '0;
        return '1;
    endfunction

    initial
    begin
        rec_t typed_r;
        rec_t r;
        res_t typed_e;
        int   set_no;
        int   set_len;
        int   pick;
        int   switch_at;
        int   rnd_sent;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_key != NO_WRITE)
                write_sort_key(plan[i].set_key[1:0]);
            typed_r.income_cents  = plan[i].income;
            typed_r.expense_cents = plan[i].expense;
            typed_r.last_record   = plan[i].last;
            send_record(typed_r);
            if (plan[i].typed)
            begin
                void'(expected_ranks.pop_back());
                typed_e.rank            = RANK_W'(1);
                typed_e.record_number   = RECNO_W'(1);
                typed_e.key_value       = plan[i].top_key;
                typed_e.dropped_records = 1'b0;
                typed_e.last_result     = 1'b1;
                expected_ranks.push_back(typed_e);
            end
        end

        set_no   = 0;
        rnd_sent = 0;
        while (rnd_sent < RANDOM_RECORDS)
        begin
            // full store and two kinds of overflow first, then mostly short sets
            case (set_no)
                0: set_len = MAX_RECORDS;
                1: set_len = MAX_RECORDS + 6;
                2: set_len = MAX_RECORDS + 1;
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 4)
                        set_len = $urandom_range(MAX_RECORDS + 3, MAX_RECORDS - 1);
                    else if (pick < 20)
                        set_len = $urandom_range(TOP_COUNT + 2, TOP_COUNT - 1);
                    else
                        set_len = $urandom_range(8, 1);
                end
            endcase
            if ($urandom_range(2) == 0)
                write_sort_key(2'($urandom_range(3)));
            switch_at = (set_len > 1 && $urandom_range(9) == 0)
                        ? $urandom_range(set_len - 1, 1) : -1;
            for (int k = 0; k < set_len; k++)
            begin
                quiet = (rnd_sent >= 150 && rnd_sent < 230);
                if (k == switch_at)
                    write_sort_key(2'($urandom_range(3)));
                r.income_cents  = random_cents();
                r.expense_cents = random_cents();
                r.last_record   = (k == set_len - 1);
                send_record(r);
                rnd_sent++;
            end
            set_no++;
        end
        quiet = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d records in %0d sets (%0d past capacity), %0d ranked entries checked",
                 records_sent, sets_closed, overflow_sets, ranks_checked);
        $display("Sort keys written: income %0d, expense %0d, balance %0d, unused selector %0d",
                 keys_used[KEY_INCOME], keys_used[KEY_EXPENSE], keys_used[KEY_BALANCE],
                 keys_used[KEY_UNUSED]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/tkds_pkg.sv
sv/tkds_key_mem.sv
sv/tkds_max_unit.sv
sv/top_k_descending_key_sorter_core.sv
bench/top_k_descending_key_sorter_core_tb.sv
